>>> rtl/lbcd_pkg.sv
`timescale 1ns / 1ps

package lbcd_pkg;

  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned BLOCK_W = 32;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_UPDATE
  } st_e;

  // front to back queue handshake
  typedef struct packed {
    logic valid;
    op_e  op;
  } q_head_t;

endpackage

>>> rtl/lru_block_cache_directory.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   action_i, block_number_i
// out       output     out_valid_o / out_stall_i hit_o, slot_o, evicted_o, evicted_block_o
//
// Front takes one transaction per cycle into a 2-deep queue while the queue is not full.
// Back handles each transaction as a tag compare, then a rank/tag update; it takes no new one until the update applies.
// Reset clears valid bits, ranks, fill count and queue; tags are not reset, no clearing pass.
// out_stall_i holds the update stage; in_stall_o rises only when the queue is full.

module lru_block_cache_directory #(
  parameter int unsigned WAYS              = 16,
  parameter int unsigned BLOCK_NUMBER_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         action_i,
  input  logic [lbcd_pkg::BLOCK_W-1:0] block_number_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o,
  output logic [lbcd_pkg::SLOT_W-1:0]  slot_o,
  output logic                         evicted_o,
  output logic [lbcd_pkg::BLOCK_W-1:0] evicted_block_o
);

  localparam int unsigned TAG_W =
    (BLOCK_NUMBER_BITS < lbcd_pkg::BLOCK_W) ? BLOCK_NUMBER_BITS : lbcd_pkg::BLOCK_W;

  lbcd_pkg::q_head_t q_head;
  logic [TAG_W-1:0]  q_tag;
  logic              q_pop;

  lbcd_front #(
    .TAG_W (TAG_W)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .block_number_i (block_number_i),
    .q_head_o       (q_head),
    .q_tag_o        (q_tag),
    .q_pop_i        (q_pop)
  );

  lbcd_back #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_head_i        (q_head),
    .q_tag_i         (q_tag),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hit_o           (hit_o),
    .slot_o          (slot_o),
    .evicted_o       (evicted_o),
    .evicted_block_o (evicted_block_o)
  );

endmodule

>>> rtl/lbcd_front.sv
`timescale 1ns / 1ps

module lbcd_front #(
  parameter int unsigned TAG_W = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         action_i,
  input  logic [lbcd_pkg::BLOCK_W-1:0] block_number_i,
  output lbcd_pkg::q_head_t            q_head_o,
  output logic [TAG_W-1:0]             q_tag_o,
  input  logic                         q_pop_i
);

  lbcd_pkg::op_e    op_q  [2];
  logic [TAG_W-1:0] tag_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             push;
  logic             pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && (cnt_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // classify on entry: clear or lookup, tag cut to directory width
  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_ptr_q]  <= action_i ? lbcd_pkg::OP_CLEAR : lbcd_pkg::OP_LOOKUP;
      tag_q[wr_ptr_q] <= TAG_W'(block_number_i);
    end
  end

  assign q_head_o.valid = (cnt_q != 2'd0);
  assign q_head_o.op    = op_q[rd_ptr_q];
  assign q_tag_o        = tag_q[rd_ptr_q];

endmodule

>>> rtl/lbcd_back.sv
`timescale 1ns / 1ps

module lbcd_back #(
  parameter int unsigned WAYS  = 16,
  parameter int unsigned TAG_W = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lbcd_pkg::q_head_t            q_head_i,
  input  logic [TAG_W-1:0]             q_tag_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o,
  output logic [lbcd_pkg::SLOT_W-1:0]  slot_o,
  output logic                         evicted_o,
  output logic [lbcd_pkg::BLOCK_W-1:0] evicted_block_o
);

  localparam int unsigned IDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RANK_W = IDX_W;
  localparam int unsigned CNT_W  = $clog2(WAYS + 1);

  lbcd_pkg::st_e     state_q, state_d;
  lbcd_pkg::op_e     op_q;
  logic [TAG_W-1:0]  work_tag_q;

  logic [TAG_W-1:0]  tag_q  [WAYS];
  logic [RANK_W-1:0] rank_q [WAYS];
  logic [WAYS-1:0]   valid_q;
  logic [CNT_W-1:0]  fill_q;

  logic [WAYS-1:0]   match_q;
  logic [WAYS-1:0]   lru_q;
  logic              full_q;

  logic                         out_valid_q, out_valid_d;
  logic                         hit_q;
  logic [lbcd_pkg::SLOT_W-1:0]  slot_q;
  logic                         evicted_q;
  logic [lbcd_pkg::BLOCK_W-1:0] evicted_block_q;

  logic              out_free;
  logic              apply;
  logic              pop;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic [IDX_W-1:0]  lru_idx;
  logic [RANK_W-1:0] old_rank;
  logic [IDX_W-1:0]  slot_sel;
  logic [TAG_W-1:0]  victim_tag;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    pop     = 1'b0;
    apply   = 1'b0;
    case (state_q)
      lbcd_pkg::ST_IDLE: begin
        if (q_head_i.valid) begin
          pop     = 1'b1;
          state_d = lbcd_pkg::ST_COMPARE;
        end
      end
      lbcd_pkg::ST_COMPARE: begin
        state_d = lbcd_pkg::ST_UPDATE;
      end
      lbcd_pkg::ST_UPDATE: begin
        if (out_free) begin
          apply = 1'b1;
          if (q_head_i.valid) begin
            pop     = 1'b1;
            state_d = lbcd_pkg::ST_COMPARE;
          end else begin
            state_d = lbcd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = lbcd_pkg::ST_IDLE;
      end
    endcase
  end

  assign q_pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lbcd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      op_q       <= q_head_i.op;
      work_tag_q <= q_tag_i;
    end
  end

  // compare stage: one comparator per way, LRU way is the one at the oldest rank
  always_ff @(posedge clk_i) begin
    if (state_q == lbcd_pkg::ST_COMPARE) begin
      for (int i = 0; i < WAYS; i++) begin
        match_q[i] <= valid_q[i] && (tag_q[i] == work_tag_q);
        lru_q[i]   <= valid_q[i] && (rank_q[i] == RANK_W'(WAYS - 1));
      end
      full_q <= (fill_q == CNT_W'(WAYS));
    end
  end

  // match and LRU vectors are one-hot, so an OR encode suffices
  always_comb begin
    hit_idx  = '0;
    lru_idx  = '0;
    old_rank = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (match_q[i]) begin
        hit_idx  = hit_idx | IDX_W'(i);
        old_rank = old_rank | rank_q[i];
      end
      if (lru_q[i]) begin
        lru_idx = lru_idx | IDX_W'(i);
      end
    end
    hit = |match_q;
    if (hit) begin
      slot_sel = hit_idx;
    end else if (!full_q) begin
      slot_sel = fill_q[IDX_W-1:0];
    end else begin
      slot_sel = lru_idx;
    end
  end

  assign victim_tag = tag_q[lru_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fill_q  <= '0;
      for (int i = 0; i < WAYS; i++) begin
        rank_q[i] <= '0;
      end
    end else if (apply) begin
      if (op_q == lbcd_pkg::OP_CLEAR) begin
        valid_q <= '0;
        fill_q  <= '0;
        for (int i = 0; i < WAYS; i++) begin
          rank_q[i] <= '0;
        end
      end else begin
        for (int i = 0; i < WAYS; i++) begin
          if (IDX_W'(i) == slot_sel) begin
            rank_q[i] <= '0;
          end else if (valid_q[i] && (!hit || (rank_q[i] < old_rank))) begin
            rank_q[i] <= rank_q[i] + RANK_W'(1);
          end
        end
        if (!hit && !full_q) begin
          valid_q[slot_sel] <= 1'b1;
          fill_q            <= fill_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply && (op_q == lbcd_pkg::OP_LOOKUP) && !hit) begin
      for (int i = 0; i < WAYS; i++) begin
        if (IDX_W'(i) == slot_sel) begin
          tag_q[i] <= work_tag_q;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (apply) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply) begin
      if (op_q == lbcd_pkg::OP_CLEAR) begin
        hit_q           <= 1'b0;
        slot_q          <= '0;
        evicted_q       <= 1'b0;
        evicted_block_q <= '0;
      end else begin
        hit_q           <= hit;
        slot_q          <= lbcd_pkg::SLOT_W'(slot_sel);
        evicted_q       <= !hit && full_q;
        evicted_block_q <= (!hit && full_q) ? lbcd_pkg::BLOCK_W'(victim_tag) : '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign slot_o          = slot_q;
  assign evicted_o       = evicted_q;
  assign evicted_block_o = evicted_block_q;

endmodule

>>> rtl/lbcd_checker.sv
`timescale 1ns / 1ps

module lbcd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         action_i,
  input logic [lbcd_pkg::BLOCK_W-1:0] block_number_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         hit_o,
  input logic [lbcd_pkg::SLOT_W-1:0]  slot_o,
  input logic                         evicted_o,
  input logic [lbcd_pkg::BLOCK_W-1:0] evicted_block_o
);

  // a stalled input transaction holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(action_i)
      && $stable(block_number_i))
    else $error("stalled input changed");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_o) && $stable(slot_o)
      && $stable(evicted_o) && $stable(evicted_block_o))
    else $error("stalled result changed");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !evicted_o)
    else $error("hit reported with eviction");

  a_evict_block_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_o |-> evicted_block_o == '0)
    else $error("evicted block nonzero without eviction");

  a_reset_idle: assert property (@(posedge clk_i)
    (!rst_ni ##1 !rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("handshake active in reset");

endmodule

bind lru_block_cache_directory lbcd_checker u_lbcd_checker (.*);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned WAYS         = 16;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic                         hit;
    logic [lbcd_pkg::SLOT_W-1:0]  slot;
    logic                         evicted;
    logic [lbcd_pkg::BLOCK_W-1:0] evicted_block;
  } dir_result_t;

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         in_valid_i     = 1'b0;
  logic                         in_stall_o;
  logic                         action_i       = lbcd_pkg::OP_LOOKUP;
  logic [lbcd_pkg::BLOCK_W-1:0] block_number_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i    = 1'b0;
  logic                         hit_o;
  logic [lbcd_pkg::SLOT_W-1:0]  slot_o;
  logic                         evicted_o;
  logic [lbcd_pkg::BLOCK_W-1:0] evicted_block_o;

  lru_block_cache_directory #(
    .WAYS             (WAYS),
    .BLOCK_NUMBER_BITS(lbcd_pkg::BLOCK_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .block_number_i (block_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .slot_o         (slot_o),
    .evicted_o      (evicted_o),
    .evicted_block_o(evicted_block_o)
  );

  always #6 clk_i = ~clk_i;

  // directory shadow
  logic [lbcd_pkg::BLOCK_W-1:0] shadow_tag [WAYS];
  bit                           shadow_vld [WAYS];
  int unsigned                  shadow_rank[WAYS];
  int unsigned                  shadow_fill;

  dir_result_t                  lookup_results_q[$];
  logic [lbcd_pkg::BLOCK_W-1:0] fill_set[16];

  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned n_sent    = 0;
  int unsigned n_checked = 0;
  int unsigned n_hits    = 0;
  int unsigned n_evicts  = 0;
  int unsigned n_clears  = 0;
  int unsigned n_errors  = 0;
  int unsigned cycles    = 0;

  function automatic void clear_shadow();
    for (int i = 0; i < WAYS; i++) begin
      shadow_vld[i]  = 1'b0;
      shadow_rank[i] = 0;
    end
    shadow_fill = 0;
  endfunction

  function automatic void promote_slot(int unsigned s, int unsigned old_rank);
    for (int unsigned i = 0; i < WAYS; i++) begin
      if (i != s && shadow_vld[i] && shadow_rank[i] < old_rank) shadow_rank[i]++;
    end
    shadow_rank[s] = 0;
  endfunction

  function automatic dir_result_t predict_lookup(lbcd_pkg::op_e op,
                                                 logic [lbcd_pkg::BLOCK_W-1:0] blk);
    dir_result_t r;
    int unsigned s;
    int unsigned best;
    bit          found;
    r     = '0;
    s     = 0;
    found = 1'b0;
    if (op == lbcd_pkg::OP_CLEAR) begin
      clear_shadow();
      n_clears++;
      return r;
    end
    for (int unsigned i = 0; i < WAYS; i++) begin
      if (!found && shadow_vld[i] && shadow_tag[i] == blk) begin
        s     = i;
        found = 1'b1;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      n_hits++;
      promote_slot(s, shadow_rank[s]);
    end else begin
      for (int unsigned i = 0; i < WAYS; i++) begin
        if (!found && !shadow_vld[i]) begin
          s     = i;
          found = 1'b1;
        end
      end
      if (found) begin
        shadow_vld[s] = 1'b1;
        shadow_tag[s] = blk;
        if (shadow_fill < WAYS) shadow_fill++;
        promote_slot(s, WAYS);
      end else begin
        best = 0;
        s    = 0;
        for (int unsigned i = 0; i < WAYS; i++) begin
          if (shadow_rank[i] > best) begin
            best = shadow_rank[i];
            s    = i;
          end
        end
        r.evicted       = 1'b1;
        r.evicted_block = shadow_tag[s];
        n_evicts++;
        shadow_tag[s] = blk;
        promote_slot(s, WAYS);
      end
    end
    r.slot = s[lbcd_pkg::SLOT_W-1:0];
    return r;
  endfunction

  task automatic send_txn(input lbcd_pkg::op_e op,
                          input logic [lbcd_pkg::BLOCK_W-1:0] blk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= op;
    block_number_i <= blk;
    do @(posedge clk_i); while (in_stall_o);
    lookup_results_q.push_back(predict_lookup(op, blk));
    n_sent++;
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
  endtask

  task automatic test_clear_empty();
    send_txn(lbcd_pkg::OP_CLEAR, 32'hFFFF_FFFF);
  endtask

  task automatic test_cold_fill();
    fill_set = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF, 32'hFFFF_0000,
                 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h1234_5678, 32'h0F0F_0F0F,
                 32'hF0F0_F0F0, 32'hDEAD_BEEF, 32'h0000_0100, 32'h0001_0000};
    for (int i = 0; i < 16; i++) send_txn(lbcd_pkg::OP_LOOKUP, fill_set[i]);
  endtask

  task automatic test_hit_promote();
    send_txn(lbcd_pkg::OP_LOOKUP, fill_set[0]);
    send_txn(lbcd_pkg::OP_LOOKUP, fill_set[1]);
  endtask

  task automatic test_eviction();
    send_txn(lbcd_pkg::OP_LOOKUP, 32'hCAFE_0001);
    send_txn(lbcd_pkg::OP_LOOKUP, 32'hCAFE_0002);
  endtask

  task automatic test_clear_refill();
    send_txn(lbcd_pkg::OP_CLEAR, 32'h0000_0000);
    send_txn(lbcd_pkg::OP_LOOKUP, fill_set[5]);
    send_txn(lbcd_pkg::OP_LOOKUP, fill_set[5]);
  endtask

  // working-set traffic: hits, fills and evictions, with some noise and clears
  task automatic test_random_mix(input int unsigned n, input int unsigned gap,
                                 input int unsigned stall);
    logic [lbcd_pkg::BLOCK_W-1:0] pool_base;
    int unsigned                  pool_span;
    int unsigned                  r;
    gap_pct   = gap;
    stall_pct = stall;
    pool_base = $urandom;
    pool_span = 20;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 50 == 0) begin
        pool_span = $urandom_range(28, 6);
        if ($urandom_range(1)) pool_base = $urandom;
      end
      r = $urandom_range(99);
      if (r < 3) send_txn(lbcd_pkg::OP_CLEAR, $urandom);
      else if (r < 13) send_txn(lbcd_pkg::OP_LOOKUP, $urandom);
      else send_txn(lbcd_pkg::OP_LOOKUP, pool_base + $urandom_range(pool_span - 1));
    end
  endtask

  always @(posedge clk_i) begin : result_check
    dir_result_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (lookup_results_q.size() == 0) begin
          $error("unexpected result transaction");
          n_errors++;
        end else begin
          exp_r = lookup_results_q.pop_front();
          n_checked++;
          if (hit_o !== exp_r.hit) begin
            $error("hit: expected %0b, actual %0b", exp_r.hit, hit_o);
            n_errors++;
          end
          if (slot_o !== exp_r.slot) begin
            $error("slot: expected %0d, actual %0d", exp_r.slot, slot_o);
            n_errors++;
          end
          if (evicted_o !== exp_r.evicted) begin
            $error("evicted: expected %0b, actual %0b", exp_r.evicted, evicted_o);
            n_errors++;
          end
          if (evicted_block_o !== exp_r.evicted_block) begin
            $error("evicted_block: expected %h, actual %h",
                   exp_r.evicted_block, evicted_block_o);
            n_errors++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    clear_shadow();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct   = 7;
    stall_pct = 81;
    test_clear_empty();
    test_cold_fill();
    test_hit_promote();
    test_eviction();
    test_clear_refill();

    test_random_mix(RANDOM_ITEMS / 3, 7, 81);
    test_random_mix(RANDOM_ITEMS / 3, 81, 7);
    test_random_mix(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0, 0);
    go_idle();

    while (lookup_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d transactions sent, %0d results checked in %0d cycles",
             n_sent, n_checked, cycles);
    $display("tb: %0d hits, %0d evictions, %0d clears, %0d mismatches",
             n_hits, n_evicts, n_clears, n_errors);
    if (n_errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
